// ===== src/lnb_pkg.sv =====
package lnb_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W = 32;
  localparam int ACC_W = 64;
  localparam int CH_W = 16;
  localparam int IN_TDATA_W = 256;
  localparam int IN_TUSER_W = 1;
  localparam int OUT_TDATA_W = 96;

  localparam logic OP_REDUCE = 1'b0;
  localparam logic OP_GRAD = 1'b1;

  localparam logic [1:0] REG_CHANNELS = 2'd0;

  // Saturate a 66-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// ===== src/lnb_mul.sv =====
// Shared 32x32 signed multiplier with registered product.
module lnb_mul (
  input  logic                clk,
  input  logic signed [31:0]  a,
  input  logic signed [31:0]  b,
  output logic signed [63:0]  p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

// ===== src/lnb_div.sv =====
// Restoring divider, 64-bit signed dividend by 16-bit unsigned divisor,
// one quotient bit per cycle, truncation toward zero.
module lnb_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic [15:0]        divisor,
  output logic               busy,
  output logic signed [63:0] quotient
);
  logic [63:0] q;
  logic [16:0] r;
  logic [6:0]  cnt;
  logic        neg;
  logic [15:0] d;
  logic [16:0] trial;

  assign trial = {r[15:0], q[63]};
  assign quotient = neg ? -$signed(q) : $signed(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 7'd64;
      neg <= dividend[63];
      q <= dividend[63] ? 64'(-dividend) : 64'(dividend);
      r <= '0;
      d <= (divisor == 16'd0) ? 16'd1 : divisor;
    end else if (busy) begin
      if (trial >= {1'b0, d}) begin
        r <= trial - {1'b0, d};
        q <= {q[62:0], 1'b1};
      end else begin
        r <= trial;
        q <= {q[62:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

// ===== src/layer_norm_backward.sv =====
// Sequencing: a reduce transaction holds the block through accept and M1..M5; the
// row's last one then runs two 64-step divides for the two means (DIV0, DIV1).
// A gradient result is loaded into the output register in M6, after M1..M5.
// The block takes a new transaction only once the last is through, paced by the
// shared multiplier; M6 stalls only while the output register is still full.
// Reset (rst, synchronous, active high): sums and means zero, channels 1, output empty.
module layer_norm_backward #(
  parameter int FRAC_BITS = lnb_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // out_grad, activation, gain, row_mean, row_rstd, grad_input_prev,
  // grad_weight_prev, grad_bias_prev
  input  logic [lnb_pkg::IN_TDATA_W-1:0]  s_tdata,
  // op
  input  logic [lnb_pkg::IN_TUSER_W-1:0]  s_tuser,
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // grad_input_out, grad_weight_out, grad_bias_out
  output logic [lnb_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                            m_tlast,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [1:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import lnb_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_M1   = 9'b000000010, // issue diff*rstd
    S_M2   = 9'b000000100, // norm lands ; issue gain*dout
    S_M3   = 9'b000001000, // dnorm lands ; issue norm*mdnn
    S_M4   = 9'b000010000, // reduce: issue dnorm*norm / grad: dval, issue norm*dout
    S_M5   = 9'b000100000, // reduce: accumulate / grad: gw, issue dval*rstd
    S_M6   = 9'b001000000, // grad: gi, load output register
    S_DIV0 = 9'b010000000,
    S_DIV1 = 9'b100000000
  } state_t;

  state_t state;
  logic               op, last;
  logic signed [31:0] dout, gain, rstd, gi_prev, gw_prev, gb_prev, diff;
  logic signed [31:0] norm, dnorm, dval, gw;
  logic signed [63:0] sum_dnorm, sum_dnorm_norm;
  logic signed [31:0] mean_dnorm, mean_dnorm_norm;
  logic [15:0]        channels;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [65:0] psh;
  logic               div_start, div_busy;
  logic signed [63:0] div_in, quo;
  logic               wr;
  logic signed [32:0] diff_s;
  logic               out_load;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign prdata = {16'd0, channels};
  always_ff @(posedge clk) begin
    if (rst) begin
      channels <= 16'd1;
    end else if (wr && paddr == REG_CHANNELS) begin
      channels <= pwdata[15:0];
    end
  end

  lnb_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(prod));
  lnb_div u_div (.clk(clk), .rst(rst), .start(div_start), .dividend(div_in),
                 .divisor(channels), .busy(div_busy), .quotient(quo));

  // product of the operands issued in the previous state, floored by FRAC_BITS
  assign psh = 66'(prod >>> FRAC_BITS);
  assign s_tready = (state == S_IDLE);
  assign diff_s = $signed({s_tdata[63], s_tdata[63:32]})
                - $signed({s_tdata[127], s_tdata[127:96]});
  // output register frees up in the same cycle it is read
  assign out_load = (state == S_M6) && (!m_tvalid || m_tready);

  // Multiplier operand select by state
  always_comb begin
    ma = diff;
    mb = rstd;
    unique case (state)
      S_IDLE, S_M1, S_DIV0, S_DIV1: begin ma = diff; mb = rstd; end
      S_M2: begin ma = gain; mb = dout; end
      S_M3: begin ma = norm; mb = mean_dnorm_norm; end
      S_M4: begin
        ma = (op == OP_GRAD) ? norm : dnorm;
        mb = (op == OP_GRAD) ? dout : norm;
      end
      // held through M6 so the product stays put during an output stall
      S_M5, S_M6: begin ma = dval; mb = rstd; end
      default: begin ma = diff; mb = rstd; end
    endcase
  end

  assign div_start = (state == S_M5 && op == OP_REDUCE && last)
                  || (state == S_DIV0 && !div_busy);
  assign div_in = (state == S_M5) ? sum_dnorm + 64'(dnorm) : sum_dnorm_norm;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      sum_dnorm <= '0;
      sum_dnorm_norm <= '0;
      mean_dnorm <= '0;
      mean_dnorm_norm <= '0;
    end else begin
      if (out_load) begin
        m_tdata <= {sat32(66'(gb_prev) + 66'(dout)), gw, sat32(66'(gi_prev) + psh)};
        m_tlast <= last;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (s_tvalid && s_tready) begin
          op <= s_tuser[0];
          dout <= s_tdata[31:0];
          gain <= s_tdata[95:64];
          rstd <= s_tdata[159:128];
          gi_prev <= s_tdata[191:160];
          gw_prev <= s_tdata[223:192];
          gb_prev <= s_tdata[255:224];
          last <= s_tlast;
          diff <= sat32(66'(diff_s));
          state <= S_M1;
        end
        S_M1: state <= S_M2;
        S_M2: begin
          norm <= sat32(psh);
          state <= S_M3;
        end
        S_M3: begin
          dnorm <= sat32(psh);
          state <= S_M4;
        end
        S_M4: begin
          if (op == OP_GRAD) begin
            dval <= sat32(66'(dnorm) - 66'(mean_dnorm) - psh);
          end
          state <= S_M5;
        end
        S_M5: begin
          if (op == OP_REDUCE) begin
            // 64-bit sums wrap
            sum_dnorm <= sum_dnorm + 64'(dnorm);
            sum_dnorm_norm <= sum_dnorm_norm + 64'(sat32(psh));
            state <= last ? S_DIV0 : S_IDLE;
          end else begin
            gw <= sat32(66'(gw_prev) + psh);
            state <= S_M6;
          end
        end
        S_M6: if (out_load) begin
          state <= S_IDLE;
        end
        S_DIV0: if (!div_busy) begin
          mean_dnorm <= sat32(66'(quo));
          sum_dnorm <= '0;
          state <= S_DIV1;
        end
        S_DIV1: if (!div_busy) begin
          mean_dnorm_norm <= sat32(66'(quo));
          sum_dnorm_norm <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== test/tb_layer_norm_backward.sv =====
`timescale 1ns / 1ps

module tb_layer_norm_backward;
  import lnb_pkg::*;

  // One input transaction. op travels in s_tuser, the eight 32-bit fields
  // fill s_tdata from out_grad up.
  typedef struct {
    logic               op;
    logic signed [31:0] dout;
    logic signed [31:0] act;
    logic signed [31:0] gain;
    logic signed [31:0] mean;
    logic signed [31:0] rstd;
    logic signed [31:0] gi_prev;
    logic signed [31:0] gw_prev;
    logic signed [31:0] gb_prev;
    logic               last;
  } elem_t;

  typedef struct {
    logic signed [31:0] gi;
    logic signed [31:0] gw;
    logic signed [31:0] gb;
    logic               last;
  } grad_t;

  // Directed row: the element, plus a typed-in result where one is obvious.
  typedef struct {
    elem_t e;
    bit    typed;
    grad_t res;
  } drow_t;

  localparam int F = FRAC_BITS_DEF;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // out_grad, activation, gain, row_mean, row_rstd, grad_input_prev,
  // grad_weight_prev, grad_bias_prev
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  // op
  logic [IN_TUSER_W-1:0]  s_tuser = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // grad_input_out, grad_weight_out, grad_bias_out
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [1:0]             paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;

  layer_norm_backward dut (.*);

  always #4 clk = ~clk;

  // Model state: channel count, row sums and the two per-row means.
  logic [15:0]    n_chan;
  longint         acc_dn;
  longint         acc_dnn;
  longint         avg_dn;
  longint         avg_dnn;

  grad_t          grad_q[$];
  int             errors = 0;
  int             n_items = 0;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Applies one element to the model; returns 1 when it yields a result.
  function automatic bit grad_step(elem_t e, output grad_t r);
    longint diff, nrm, dn, dnn, dv, dvz;
    diff = clip32(longint'(e.act) - longint'(e.mean));
    nrm  = clip32((diff * longint'(e.rstd)) >>> F);
    dn   = clip32((longint'(e.gain) * longint'(e.dout)) >>> F);
    r = '{default: '0};
    if (e.op == OP_REDUCE) begin
      dnn = clip32((dn * nrm) >>> F);
      acc_dn  = acc_dn + dn;     // 64-bit sums wrap
      acc_dnn = acc_dnn + dnn;
      if (e.last) begin
        dvz = (n_chan == 0) ? 1 : longint'(n_chan);
        avg_dn  = clip32(acc_dn / dvz);
        avg_dnn = clip32(acc_dnn / dvz);
        acc_dn  = 0;
        acc_dnn = 0;
      end
      return 1'b0;
    end
    dv = clip32(dn - avg_dn - ((nrm * avg_dnn) >>> F));
    r.gi = 32'(clip32(longint'(e.gi_prev) + ((dv * longint'(e.rstd)) >>> F)));
    r.gw = 32'(clip32(longint'(e.gw_prev) + ((nrm * longint'(e.dout)) >>> F)));
    r.gb = 32'(clip32(longint'(e.gb_prev) + longint'(e.dout)));
    r.last = e.last;
    return 1'b1;
  endfunction

  // Mostly uniform values, with a fair share of extremes and small ones.
  function automatic logic signed [31:0] pick32();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'($signed($urandom_range(0, 262143)) - 131072);
      3: return 32'($signed($urandom_range(0, 131071)));
      default: return $urandom;
    endcase
  endfunction

  function automatic elem_t rand_elem(logic op, logic last);
    elem_t e;
    e.op = op;
    e.dout = pick32();
    e.act = pick32();
    e.gain = pick32();
    e.mean = pick32();
    e.rstd = pick32();
    e.gi_prev = pick32();
    e.gw_prev = pick32();
    e.gb_prev = pick32();
    e.last = last;
    return e;
  endfunction

  // APB write, setup then access phase; register 0 at byte address 0.
  task automatic set_channels(logic [15:0] v);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 2'(REG_CHANNELS * 4);
    pwdata <= {16'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    n_chan = v;
  endtask

  // Block idle: all results in, then room for a trailing row-end divide.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (grad_q.size() != 0) @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  // Sender: bursts, with occasional random gaps. tvalid stays high
  // across back-to-back transactions.
  int burst_left = 0;

  task automatic send(elem_t e, bit typed = 1'b0, grad_t tres = '{default: '0});
    grad_t r;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0 && s_tvalid) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else if (gap != 0) begin
        repeat (gap - 1) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {e.gb_prev, e.gw_prev, e.gi_prev, e.rstd, e.mean,
                e.gain, e.act, e.dout};
    s_tuser <= e.op;
    s_tlast <= e.last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_items++;
    if (grad_step(e, r)) grad_q.push_back(typed ? tres : r);
  endtask

  // Receiver stalls in a pattern of its own: free running phases and
  // phases with random stalls.
  int rx_mode = 0;
  int rx_cnt = 0;
  always @(posedge clk) begin
    if (rx_cnt == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_cnt <= $urandom_range(20, 200);
    end else begin
      rx_cnt <= rx_cnt - 1;
    end
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // Result checker: each output transaction against the oldest expectation.
  always @(posedge clk) begin
    grad_t x;
    if (!rst && m_tvalid && m_tready) begin
      if (grad_q.size() == 0) begin
        $display("%t unexpected result gi=%h gw=%h gb=%h last=%b", $time,
                 m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tlast);
        errors++;
      end else begin
        x = grad_q.pop_front();
        if (m_tdata[31:0] !== x.gi) begin
          $display("%t grad_input: expected %h got %h", $time, x.gi, m_tdata[31:0]);
          errors++;
        end
        if (m_tdata[63:32] !== x.gw) begin
          $display("%t grad_weight: expected %h got %h", $time, x.gw, m_tdata[63:32]);
          errors++;
        end
        if (m_tdata[95:64] !== x.gb) begin
          $display("%t grad_bias: expected %h got %h", $time, x.gb, m_tdata[95:64]);
          errors++;
        end
        if (m_tlast !== x.last) begin
          $display("%t last: expected %b got %b", $time, x.last, m_tlast);
          errors++;
        end
      end
    end
  end

  // Directed rows. The first two run with zero means after reset, so only
  // the bias gradient moves and it clips at either rail.
  drow_t dirs[] = '{
    '{'{OP_GRAD, 32'sh7FFFFFFF, 0, 0, 0, 0, 5, -7, 32'sh3FFFFFFF, 1'b1},
      1'b1, '{32'sd5, -32'sd7, 32'sh7FFFFFFF, 1'b1}},
    '{'{OP_GRAD, 32'sh80000000, 0, 0, 0, 0, 32'sh7FFFFFFF, 32'sh80000000,
        32'shC0000000, 1'b0},
      1'b1, '{32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 1'b0}},
    // reduce a 3-element row with extreme products, then its gradients
    '{'{OP_REDUCE, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
        32'sh7FFFFFFF, 0, 0, 0, 1'b0}, 1'b0, '{default: '0}},
    '{'{OP_REDUCE, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
        32'sh80000000, 0, 0, 0, 1'b0}, 1'b0, '{default: '0}},
    '{'{OP_REDUCE, 32'sh00010000, 32'sh00020000, 32'sh00010000, 32'sh00008000,
        32'sh00010000, 0, 0, 0, 1'b1}, 1'b0, '{default: '0}},
    '{'{OP_GRAD, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
        32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh3FFFFFFF, 1'b0},
      1'b0, '{default: '0}},
    '{'{OP_GRAD, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
        32'sh80000000, 32'sh80000000, 32'sh80000000, 32'shC0000000, 1'b0},
      1'b0, '{default: '0}},
    '{'{OP_GRAD, 32'sh00010000, 32'sh00020000, 32'sh00010000, 32'sh00008000,
        32'sh00010000, 32'shFFFF0000, 32'sh00001234, 32'sh00000001, 1'b1},
      1'b0, '{default: '0}},
    // single-element row with negative values, odd floors
    '{'{OP_REDUCE, -32'sd3, -32'sd5, 32'sh00018000, 32'sd7, -32'sd1,
        0, 0, 0, 1'b1}, 1'b0, '{default: '0}},
    '{'{OP_GRAD, -32'sd3, -32'sd5, 32'sh00018000, 32'sd7, -32'sd1,
        -32'sd9, 32'sd11, -32'sd13, 1'b1}, 1'b0, '{default: '0}}
  };

  initial begin
    int phase, rows, len, k;
    logic [15:0] chan;
    elem_t row[$];
    n_chan = 1;
    acc_dn = 0;
    acc_dnn = 0;
    avg_dn = 0;
    avg_dnn = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dirs[i]) send(dirs[i].e, dirs[i].typed, dirs[i].res);

    // Zero channels divides by one; full-scale channels shrinks the means.
    for (phase = 0; n_items < 830; phase++) begin
      drain();
      case (phase % 5)
        0: chan = 16'd0;
        1: chan = 16'hFFFF;
        2: chan = 16'd1;
        default: chan = 16'($urandom_range(1, 12));
      endcase
      set_channels(chan);
      rows = $urandom_range(3, 10);
      for (int r = 0; r < rows; r++) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: loose elements with random op and last
          repeat ($urandom_range(1, 6)) send(rand_elem(1'($urandom), 1'($urandom)));
        end else begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20)
                                            : $urandom_range(1, 6);
          row.delete();
          for (k = 0; k < len; k++) row.push_back(rand_elem(OP_REDUCE, k == len - 1));
          foreach (row[j]) send(row[j]);
          // gradient pass over the same row, fresh running gradients
          foreach (row[j]) begin
            elem_t g;
            g = rand_elem(OP_GRAD, row[j].last);
            g.dout = row[j].dout;
            g.act = row[j].act;
            g.gain = row[j].gain;
            g.mean = row[j].mean;
            g.rstd = row[j].rstd;
            send(g);
          end
        end
        // hold the sender once until the output side is empty
        if (phase == 2 && r == 0) begin
          s_tvalid <= 1'b0;
          burst_left = 0;
          while (grad_q.size() != 0) @(posedge clk);
        end
      end
    end

    drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
